/* rtl/i2c_master_byte_engine_top_defines.svh */
// assertion macros shared by the front end and engine modules
`ifndef I2C_MASTER_BYTE_ENGINE_TOP_DEFINES_SVH
`define I2C_MASTER_BYTE_ENGINE_TOP_DEFINES_SVH

// consequent must hold in the same cycle as the antecedent
`define I2CM_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent must hold in the cycle after the antecedent
`define I2CM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/i2cm_pkg.sv */
package i2cm_pkg;

    localparam int TICKS_W   = 16;
    localparam int BYTE_W    = 8;
    localparam int PHASE_W   = 5;
    localparam int Q_DEPTH   = 2;
    localparam int Q_PTR_W   = 1;
    localparam int Q_CNT_W   = 2;

    localparam logic [TICKS_W-1:0] TICKS_RESET = 16'd10;
    localparam logic [PHASE_W-1:0] PHASE_MAX   = 5'd26;
    localparam logic [Q_CNT_W-1:0] Q_FULL_CNT  = 2'd2;

    // bus command codes as they arrive on req_type
    typedef enum logic [2:0] {
        CMD_NONE  = 3'd0,
        CMD_START = 3'd1,
        CMD_WRITE = 3'd2,
        CMD_READ  = 3'd3,
        CMD_STOP  = 3'd4
    } cmd_t;

    // pin change made on the first tick of a phase
    typedef enum logic [2:0] {
        ACT_NONE,
        ACT_SDA_HI,
        ACT_SDA_LO,
        ACT_SCL_HI,
        ACT_SCL_LO,
        ACT_SDA_BIT,
        ACT_SDA_NACK
    } act_t;

    // bus sample taken on the last tick of a phase
    typedef enum logic [1:0] {
        SMP_NONE,
        SMP_ACK,
        SMP_RX
    } smp_t;

    typedef struct packed {
        act_t act;
        smp_t smp;
    } phase_info_t;

    // classified tick item between front end and engine
    typedef struct packed {
        cmd_t              cmd;
        logic [BYTE_W-1:0] wr_byte;
        logic              send_nack;
        logic              sda_in;
    } item_t;

    // per-tick result
    typedef struct packed {
        logic              scl_out;
        logic              sda_out;
        logic              busy_res;
        logic              cmd_done;
        logic [BYTE_W-1:0] rx_byte;
        logic              nack_seen;
        logic              cmd_ignored;
    } res_t;

    // number of phases in each command
    function automatic logic [PHASE_W-1:0] phase_total(input cmd_t cmd);
        logic [PHASE_W-1:0] n;
        unique case (cmd)
            CMD_START: n = 5'd4;
            CMD_WRITE: n = 5'd27;
            CMD_READ:  n = 5'd20;
            CMD_STOP:  n = 5'd3;
            default:   n = 5'd0;
        endcase
        return n;
    endfunction

    // phase table: pin action and sample for each command and phase
    function automatic phase_info_t phase_info(input cmd_t cmd, input logic [PHASE_W-1:0] p);
        phase_info_t pi;
        pi.act = ACT_NONE;
        pi.smp = SMP_NONE;
        unique case (cmd)
            CMD_START: begin
                unique case (p)
                    5'd0:    pi.act = ACT_SDA_HI;
                    5'd1:    pi.act = ACT_SCL_HI;
                    5'd2:    pi.act = ACT_SDA_LO;
                    default: pi.act = ACT_SCL_LO;
                endcase
            end
            CMD_WRITE: begin
                unique case (p) inside
                    5'd0, 5'd3, 5'd6, 5'd9, 5'd12, 5'd15, 5'd18, 5'd21:
                        pi.act = ACT_SDA_BIT;
                    5'd1, 5'd4, 5'd7, 5'd10, 5'd13, 5'd16, 5'd19, 5'd22:
                        pi.act = ACT_SCL_HI;
                    5'd24:
                        pi.act = ACT_SDA_HI;
                    5'd25: begin
                        pi.act = ACT_SCL_HI;
                        pi.smp = SMP_ACK;
                    end
                    default:
                        pi.act = ACT_SCL_LO;
                endcase
            end
            CMD_READ: begin
                unique case (p) inside
                    5'd0:
                        pi.act = ACT_SDA_HI;
                    5'd1, 5'd3, 5'd5, 5'd7, 5'd9, 5'd11, 5'd13, 5'd15: begin
                        pi.act = ACT_SCL_HI;
                        pi.smp = SMP_RX;
                    end
                    5'd17:
                        pi.act = ACT_SDA_NACK;
                    5'd18:
                        pi.act = ACT_SCL_HI;
                    default:
                        pi.act = ACT_SCL_LO;
                endcase
            end
            CMD_STOP: begin
                unique case (p)
                    5'd0:    pi.act = ACT_SDA_LO;
                    5'd1:    pi.act = ACT_SCL_HI;
                    default: pi.act = ACT_SDA_HI;
                endcase
            end
            default: pi.act = ACT_NONE;
        endcase
        return pi;
    endfunction

endpackage

/* rtl/i2cm_front.sv */
`include "i2c_master_byte_engine_top_defines.svh"

module i2cm_front
    import i2cm_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    output logic              full,
    input  logic [2:0]        req_type,
    input  logic [BYTE_W-1:0] wr_byte,
    input  logic              send_nack,
    input  logic              sda_in,
    output logic              item_valid,
    output item_t             item,
    input  logic              item_pop
);

    item_t                mem_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0]   wr_ptr_reg;
    logic [Q_PTR_W-1:0]   rd_ptr_reg;
    logic [Q_CNT_W-1:0]   count_reg;
    logic [Q_CNT_W-1:0]   count_next;
    logic                 push_ok;
    logic                 pop_ok;
    cmd_t                 cmd_dec;
    item_t                item_in;

    // classify request code, out-of-range codes carry no command
    always_comb
    begin
        unique case (req_type)
            CMD_START: cmd_dec = CMD_START;
            CMD_WRITE: cmd_dec = CMD_WRITE;
            CMD_READ:  cmd_dec = CMD_READ;
            CMD_STOP:  cmd_dec = CMD_STOP;
            default:   cmd_dec = CMD_NONE;
        endcase
        item_in.cmd       = cmd_dec;
        item_in.wr_byte   = wr_byte;
        item_in.send_nack = send_nack;
        item_in.sda_in    = sda_in;
    end

    assign full       = (count_reg == Q_FULL_CNT);
    assign item_valid = (count_reg != '0);
    assign push_ok    = push && !full;
    assign pop_ok     = item_pop && item_valid;
    assign item       = mem_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push_ok && !pop_ok)
        begin
            count_next = count_reg + Q_CNT_W'(1);
        end
        else if (!push_ok && pop_ok)
        begin
            count_next = count_reg - Q_CNT_W'(1);
        end
    end

    // queue storage
    always_ff @(posedge clk)
    begin
        if (push_ok)
        begin
            mem_reg[wr_ptr_reg] <= item_in;
        end
    end

    // queue pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push_ok)
            begin
                wr_ptr_reg <= wr_ptr_reg + Q_PTR_W'(1);
            end
            if (pop_ok)
            begin
                rd_ptr_reg <= rd_ptr_reg + Q_PTR_W'(1);
            end
            count_reg <= count_next;
        end
    end

    `I2CM_ASSERT_NEXT(a_front_fill, push_ok && !pop_ok,
                      count_reg == $past(count_reg) + Q_CNT_W'(1), "front queue did not grow")
    `I2CM_ASSERT_NEXT(a_front_drain, pop_ok && !push_ok,
                      count_reg == $past(count_reg) - Q_CNT_W'(1), "front queue did not shrink")
    `I2CM_ASSERT_NOW(a_front_bound, 1'b1, count_reg <= Q_FULL_CNT, "front queue overfilled")

endmodule

/* rtl/i2cm_engine.sv */
`include "i2c_master_byte_engine_top_defines.svh"

module i2cm_engine
    import i2cm_pkg::*;
#(
    parameter int CNT_W = 16
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               phase_ticks_we,
    input  logic [TICKS_W-1:0] phase_ticks_wdata,
    input  logic               item_valid,
    input  item_t              item,
    output logic               item_pop,
    input  logic               res_full,
    output logic               res_push,
    output res_t               res
);

    localparam int HW = (CNT_W > TICKS_W) ? CNT_W : TICKS_W;

    cmd_t               cmd_reg,        cmd_next;
    logic [PHASE_W-1:0] phase_reg,      phase_next;
    logic [CNT_W-1:0]   cnt_reg,        cnt_next;
    logic [BYTE_W-1:0]  shift_reg,      shift_next;
    logic               scl_reg,        scl_next;
    logic               sda_reg,        sda_next;
    logic               ack_reg,        ack_next;
    logic               nack_req_reg,   nack_req_next;
    logic [BYTE_W-1:0]  rx_reg,         rx_next;
    logic [TICKS_W-1:0] phase_ticks_reg;
    logic [TICKS_W-1:0] phase_ticks_next;

    logic               fire;
    logic               ignored;
    logic               done;
    logic [HW-1:0]      pt_ext;
    logic [HW-1:0]      cmax_ext;
    logic [HW-1:0]      hold_ext;
    logic [CNT_W-1:0]   hold;
    logic [CNT_W-1:0]   cnt_inc;
    logic [PHASE_W:0]   phase_inc;
    phase_info_t        pinfo;

    assign fire     = item_valid && !res_full;
    assign item_pop = fire;
    assign res_push = fire;

    // hold length: zero means one, clipped to what the counter can reach
    always_comb
    begin
        pt_ext   = HW'(phase_ticks_reg);
        cmax_ext = HW'({CNT_W{1'b1}});
        hold_ext = (pt_ext > cmax_ext) ? cmax_ext : pt_ext;
        hold     = CNT_W'(hold_ext);
        if (hold == '0)
        begin
            hold = CNT_W'(1);
        end
    end

    // one tick of the bus sequencer
    always_comb
    begin
        cmd_next      = cmd_reg;
        phase_next    = phase_reg;
        cnt_next      = cnt_reg;
        shift_next    = shift_reg;
        scl_next      = scl_reg;
        sda_next      = sda_reg;
        ack_next      = ack_reg;
        nack_req_next = nack_req_reg;
        rx_next       = rx_reg;
        ignored       = 1'b0;
        done          = 1'b0;
        pinfo         = phase_info(cmd_reg, phase_reg);
        cnt_inc       = '0;
        phase_inc     = '0;

        if (fire)
        begin
            // take a new command when idle, drop it when busy
            if (cmd_reg == CMD_NONE)
            begin
                if (item.cmd != CMD_NONE)
                begin
                    cmd_next   = item.cmd;
                    phase_next = '0;
                    cnt_next   = '0;
                    if (item.cmd == CMD_WRITE)
                    begin
                        shift_next = item.wr_byte;
                    end
                    if (item.cmd == CMD_READ)
                    begin
                        shift_next    = '0;
                        nack_req_next = item.send_nack;
                    end
                end
            end
            else if (item.cmd != CMD_NONE)
            begin
                ignored = 1'b1;
            end

            if (cmd_next != CMD_NONE)
            begin
                pinfo = phase_info(cmd_next, phase_next);

                // pin change on the first tick of the phase
                if (cnt_next == '0)
                begin
                    case (pinfo.act)
                        ACT_SDA_HI:   sda_next = 1'b1;
                        ACT_SDA_LO:   sda_next = 1'b0;
                        ACT_SCL_HI:   scl_next = 1'b1;
                        ACT_SCL_LO:   scl_next = 1'b0;
                        ACT_SDA_NACK: sda_next = nack_req_next;
                        ACT_SDA_BIT:
                        begin
                            sda_next   = shift_next[BYTE_W-1];
                            shift_next = {shift_next[BYTE_W-2:0], 1'b0};
                        end
                        default:      sda_next = sda_next;
                    endcase
                end

                cnt_inc = cnt_next + CNT_W'(1);
                if (cnt_inc >= hold)
                begin
                    // sample on the last tick, then move to the next phase
                    case (pinfo.smp)
                        SMP_ACK: ack_next   = item.sda_in;
                        SMP_RX:  shift_next = {shift_next[BYTE_W-2:0], item.sda_in};
                        default: ack_next   = ack_next;
                    endcase
                    cnt_next  = '0;
                    phase_inc = {1'b0, phase_next} + (PHASE_W+1)'(1);
                    if (phase_inc >= {1'b0, phase_total(cmd_next)})
                    begin
                        if (cmd_next == CMD_READ)
                        begin
                            rx_next  = shift_next;
                            sda_next = 1'b1;
                        end
                        cmd_next   = CMD_NONE;
                        phase_next = '0;
                        done       = 1'b1;
                    end
                    else
                    begin
                        phase_next = phase_inc[PHASE_W-1:0];
                    end
                end
                else
                begin
                    cnt_next = cnt_inc;
                end
            end
        end
    end

    // configuration write
    assign phase_ticks_next = phase_ticks_we ? phase_ticks_wdata : phase_ticks_reg;

    always_comb
    begin
        res.scl_out     = scl_next;
        res.sda_out     = sda_next;
        res.busy_res    = (cmd_next != CMD_NONE);
        res.cmd_done    = done;
        res.rx_byte     = rx_next;
        res.nack_seen   = ack_next;
        res.cmd_ignored = ignored;
    end

    // sequencer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_reg         <= CMD_NONE;
            phase_reg       <= '0;
            cnt_reg         <= '0;
            shift_reg       <= '0;
            scl_reg         <= 1'b1;
            sda_reg         <= 1'b1;
            ack_reg         <= 1'b0;
            nack_req_reg    <= 1'b0;
            rx_reg          <= '0;
            phase_ticks_reg <= TICKS_RESET;
        end
        else
        begin
            cmd_reg         <= cmd_next;
            phase_reg       <= phase_next;
            cnt_reg         <= cnt_next;
            shift_reg       <= shift_next;
            scl_reg         <= scl_next;
            sda_reg         <= sda_next;
            ack_reg         <= ack_next;
            nack_req_reg    <= nack_req_next;
            rx_reg          <= rx_next;
            phase_ticks_reg <= phase_ticks_next;
        end
    end

    `I2CM_ASSERT_NOW(a_done_idle, fire && done, !res.busy_res, "engine busy after command done")
    `I2CM_ASSERT_NOW(a_ignored_busy, fire && ignored, cmd_reg != CMD_NONE, "command dropped while idle")
    `I2CM_ASSERT_NOW(a_idle_clean, cmd_reg == CMD_NONE, phase_reg == '0 && cnt_reg == '0, "idle engine holds phase or count")
    `I2CM_ASSERT_NOW(a_phase_range, cmd_reg != CMD_NONE, phase_reg <= PHASE_MAX, "phase index out of range")

endmodule

/* rtl/i2cm_outq.sv */
module i2cm_outq
    import i2cm_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic res_push,
    output logic res_full,
    input  res_t res_in,
    output logic empty,
    input  logic pop,
    output res_t res_out
);

    res_t               mem_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0] wr_ptr_reg;
    logic [Q_PTR_W-1:0] rd_ptr_reg;
    logic [Q_CNT_W-1:0] count_reg;
    logic [Q_CNT_W-1:0] count_next;
    logic               push_ok;
    logic               pop_ok;

    assign res_full = (count_reg == Q_FULL_CNT);
    assign empty    = (count_reg == '0);
    assign push_ok  = res_push && !res_full;
    assign pop_ok   = pop && !empty;
    assign res_out  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push_ok && !pop_ok)
        begin
            count_next = count_reg + Q_CNT_W'(1);
        end
        else if (!push_ok && pop_ok)
        begin
            count_next = count_reg - Q_CNT_W'(1);
        end
    end

    // result storage
    always_ff @(posedge clk)
    begin
        if (push_ok)
        begin
            mem_reg[wr_ptr_reg] <= res_in;
        end
    end

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push_ok)
            begin
                wr_ptr_reg <= wr_ptr_reg + Q_PTR_W'(1);
            end
            if (pop_ok)
            begin
                rd_ptr_reg <= rd_ptr_reg + Q_PTR_W'(1);
            end
            count_reg <= count_next;
        end
    end

endmodule

/* rtl/i2c_master_byte_engine_top.sv */
// channel   | direction | handshake      | payload
// ----------+-----------+----------------+--------------------------------------------
// tick in   | input     | push / full    | req_type, wr_byte, send_nack, sda_in
// result    | output    | pop / empty    | scl_out, sda_out, busy_res, cmd_done,
//           |           |                | rx_byte, nack_seen, cmd_ignored
// config    | input     | phase_ticks_we | phase_ticks_wdata
//
// one tick item per clock cycle sustained while the result queue has room; a result
// goes through the front queue, then the sequencer writes it into the result queue
// the combinational sequencer step (hold counter compare, phase table) sets that rate
// rst_n is asynchronous, active low; after reset SCL and SDA are released, hold is 10
// two-entry queues on both sides; from empty with pop held low, four ticks go in
// before full rises
module i2c_master_byte_engine_top
    import i2cm_pkg::*;
#(
    parameter int TICK_COUNTER_WIDTH = 16
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  logic [2:0]         req_type,
    input  logic [BYTE_W-1:0]  wr_byte,
    input  logic               send_nack,
    input  logic               sda_in,
    input  logic               pop,
    output logic               empty,
    output logic               scl_out,
    output logic               sda_out,
    output logic               busy_res,
    output logic               cmd_done,
    output logic [BYTE_W-1:0]  rx_byte,
    output logic               nack_seen,
    output logic               cmd_ignored,
    input  logic               phase_ticks_we,
    input  logic [TICKS_W-1:0] phase_ticks_wdata
);

    item_t item;
    logic  item_valid;
    logic  item_pop;
    logic  res_push;
    logic  res_full;
    res_t  res_in;
    res_t  res_out;

    // accept and classify tick items
    i2cm_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .req_type   (req_type),
        .wr_byte    (wr_byte),
        .send_nack  (send_nack),
        .sda_in     (sda_in),
        .item_valid (item_valid),
        .item       (item),
        .item_pop   (item_pop)
    );

    // bus phase sequencer
    i2cm_engine #(
        .CNT_W (TICK_COUNTER_WIDTH)
    ) u_engine (
        .clk               (clk),
        .rst_n             (rst_n),
        .phase_ticks_we    (phase_ticks_we),
        .phase_ticks_wdata (phase_ticks_wdata),
        .item_valid        (item_valid),
        .item              (item),
        .item_pop          (item_pop),
        .res_full          (res_full),
        .res_push          (res_push),
        .res               (res_in)
    );

    // result queue
    i2cm_outq u_outq (
        .clk      (clk),
        .rst_n    (rst_n),
        .res_push (res_push),
        .res_full (res_full),
        .res_in   (res_in),
        .empty    (empty),
        .pop      (pop),
        .res_out  (res_out)
    );

    assign scl_out     = res_out.scl_out;
    assign sda_out     = res_out.sda_out;
    assign busy_res    = res_out.busy_res;
    assign cmd_done    = res_out.cmd_done;
    assign rx_byte     = res_out.rx_byte;
    assign nack_seen   = res_out.nack_seen;
    assign cmd_ignored = res_out.cmd_ignored;

endmodule
